>>> rtl/afbd_pkg.sv
// afbd_pkg: types, widths, register codes and reset values for the
// anchor-free box decode filter. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package afbd_pkg;

    localparam int MAX_LEVELS     = 3;
    localparam int NUM_LEVELS_DEF = 3;

    localparam int LEVEL_W    = 2;
    localparam int CELL_W     = 10;
    localparam int LOGIT_W    = 16;
    localparam int DIST_W     = 16;
    localparam int COORD_W    = 16;
    localparam int SIZE_W     = 12;
    localparam int STRIDE_W   = 7;
    localparam int FRAC_W     = 4;
    localparam int PROD_W     = CELL_W + STRIDE_W;
    localparam int PX_W       = PROD_W + FRAC_W;
    localparam int EDGE_W     = PX_W + 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic signed [LOGIT_W-1:0] LOGIT_THR_RST = -16'sd281;
    localparam logic [COORD_W-1:0]        MIN_SIZE_RST  = 16'd64;
    localparam logic [SIZE_W-1:0]         MODEL_W_RST   = 12'd640;
    localparam logic [SIZE_W-1:0]         MODEL_H_RST   = 12'd640;
    localparam logic [MAX_LEVELS-1:0][STRIDE_W-1:0] STRIDE_RST = {7'd32, 7'd16, 7'd8};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOGIT_THR = 3'd0,
        CFG_MIN_SIZE  = 3'd1,
        CFG_MODEL_W   = 3'd2,
        CFG_MODEL_H   = 3'd3,
        CFG_STRIDE0   = 3'd4,
        CFG_STRIDE1   = 3'd5,
        CFG_STRIDE2   = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [LEVEL_W-1:0]        level;
        logic [CELL_W-1:0]         cell_col;
        logic [CELL_W-1:0]         cell_row;
        logic signed [LOGIT_W-1:0] cell_logit;
        logic signed [DIST_W-1:0]  dist_left;
        logic signed [DIST_W-1:0]  dist_top;
        logic signed [DIST_W-1:0]  dist_right;
        logic signed [DIST_W-1:0]  dist_bottom;
    } t_cell;

    typedef struct packed {
        logic [COORD_W-1:0]        box_x1;
        logic [COORD_W-1:0]        box_y1;
        logic [COORD_W-1:0]        box_x2;
        logic [COORD_W-1:0]        box_y2;
        logic signed [LOGIT_W-1:0] box_logit;
    } t_box;

    typedef struct packed {
        logic signed [LOGIT_W-1:0]                logit_threshold;
        logic [COORD_W-1:0]                       min_box_size;
        logic [SIZE_W-1:0]                        model_width;
        logic [SIZE_W-1:0]                        model_height;
        logic [MAX_LEVELS-1:0][STRIDE_W-1:0]      stride;
    } t_cfg;

    typedef struct packed {
        logic                      valid;
        logic signed [EDGE_W-1:0]  x1;
        logic signed [EDGE_W-1:0]  y1;
        logic signed [EDGE_W-1:0]  x2;
        logic signed [EDGE_W-1:0]  y2;
        logic signed [LOGIT_W-1:0] logit;
    } t_edges;

endpackage

`default_nettype wire

>>> rtl/afbd_cell_if.sv
// afbd_cell_if: valid/ready channel carrying one grid cell per transaction.
// Depends on afbd_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface afbd_cell_if
    import afbd_pkg::*;
();
    logic  valid;
    logic  ready;
    t_cell data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/afbd_box_if.sv
// afbd_box_if: valid/ready channel carrying one decoded box per transaction.
// Depends on afbd_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface afbd_box_if
    import afbd_pkg::*;
();
    logic valid;
    logic ready;
    t_box data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/anchor_free_box_decode_filter.sv
// Anchor-free box decode filter: one grid cell in, zero or one clamped box out per
// transaction, one cell per clock while not stalled. Two register stages: the first
// holds the raw edges (prior point from a 10x7 multiply plus the distances), the
// second the clamped box after the size test. Cells whose logit is below the
// threshold or whose level is out of range are dropped before the first stage;
// boxes not wider and taller than the minimum size are dropped before the second.
// Each stage advances when the next one is empty or being drained, so a stalled
// output only stops input once both stages are full. The user writes configuration
// through the plain write port only while the block is idle; this is not enforced.
// Depends on afbd_pkg, afbd_cell_if, afbd_box_if, afbd_cfg, afbd_decode, afbd_clip.
`timescale 1ns / 1ps
`default_nettype none

module anchor_free_box_decode_filter
    import afbd_pkg::*;
#(
    parameter int NUM_LEVELS = NUM_LEVELS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    afbd_cell_if.sink                  i_cell,
    afbd_box_if.source                 o_box
);

    t_cfg   w_cfg;
    t_edges w_edges;
    logic   w_clip_ready;

    afbd_cfg #(
        .NUM_LEVELS (NUM_LEVELS)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    afbd_decode #(
        .NUM_LEVELS (NUM_LEVELS)
    ) u_decode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_cell       (i_cell),
        .i_next_ready (w_clip_ready),
        .o_edges      (w_edges)
    );

    afbd_clip u_clip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_edges (w_edges),
        .o_ready (w_clip_ready),
        .o_box   (o_box)
    );

endmodule

`default_nettype wire

>>> rtl/afbd_cfg.sv
// afbd_cfg: configuration register file written through the plain write port.
// Depends on afbd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module afbd_cfg
    import afbd_pkg::*;
#(
    parameter int NUM_LEVELS = NUM_LEVELS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                       o_cfg
);

    logic signed [LOGIT_W-1:0] r_thr;
    logic [COORD_W-1:0]        r_min;
    logic [SIZE_W-1:0]         r_mw;
    logic [SIZE_W-1:0]         r_mh;
    logic                      w_stride_sel;
    logic [LEVEL_W-1:0]        w_stride_lvl;

    always_comb begin
        w_stride_sel = 1'b0;
        w_stride_lvl = '0;
        case (t_cfg_idx'(i_cfg_idx))
            CFG_STRIDE0: begin
                w_stride_sel = 1'b1;
                w_stride_lvl = LEVEL_W'(0);
            end
            CFG_STRIDE1: begin
                w_stride_sel = 1'b1;
                w_stride_lvl = LEVEL_W'(1);
            end
            CFG_STRIDE2: begin
                w_stride_sel = 1'b1;
                w_stride_lvl = LEVEL_W'(2);
            end
            default: begin
                w_stride_sel = 1'b0;
                w_stride_lvl = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= LOGIT_THR_RST;
            r_min <= MIN_SIZE_RST;
            r_mw  <= MODEL_W_RST;
            r_mh  <= MODEL_H_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_LOGIT_THR: r_thr <= $signed(i_cfg_data[LOGIT_W-1:0]);
                CFG_MIN_SIZE:  r_min <= i_cfg_data[COORD_W-1:0];
                CFG_MODEL_W:   r_mw  <= i_cfg_data[SIZE_W-1:0];
                CFG_MODEL_H:   r_mh  <= i_cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    for (genvar g = 0; g < MAX_LEVELS; g++) begin : g_stride
        if (g < NUM_LEVELS) begin : g_reg
            logic [STRIDE_W-1:0] r_stride;
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_stride <= STRIDE_RST[g];
                end else if (i_cfg_we && w_stride_sel && w_stride_lvl == LEVEL_W'(g)) begin
                    r_stride <= i_cfg_data[STRIDE_W-1:0];
                end
            end
            assign o_cfg.stride[g] = r_stride;
        end else begin : g_none
            assign o_cfg.stride[g] = '0;
        end
    end

    assign o_cfg.logit_threshold = r_thr;
    assign o_cfg.min_box_size    = r_min;
    assign o_cfg.model_width     = r_mw;
    assign o_cfg.model_height    = r_mh;

endmodule

`default_nettype wire

>>> rtl/afbd_decode.sv
// afbd_decode: threshold test, stride select, prior point and raw box edges,
// registered into the edge stage. Depends on afbd_pkg and afbd_cell_if.
`timescale 1ns / 1ps
`default_nettype none

module afbd_decode
    import afbd_pkg::*;
#(
    parameter int NUM_LEVELS = NUM_LEVELS_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  t_cfg        i_cfg,
    afbd_cell_if.sink   i_cell,
    input  wire logic   i_next_ready,
    output t_edges      o_edges
);

    logic                r_valid;
    t_edges              r_edges;
    t_edges              n_edges;
    logic [STRIDE_W-1:0] w_stride;
    logic                w_lvl_ok;
    logic [PROD_W-1:0]   w_px_cells;
    logic [PROD_W-1:0]   w_py_cells;
    logic [PX_W-1:0]     w_px;
    logic [PX_W-1:0]     w_py;
    logic                w_keep;
    logic                w_ready;

    always_comb begin
        w_stride = '0;
        w_lvl_ok = 1'b0;
        for (int i = 0; i < NUM_LEVELS; i++) begin
            if (i_cell.data.level == LEVEL_W'(i)) begin
                w_stride = i_cfg.stride[i];
                w_lvl_ok = 1'b1;
            end
        end
    end

    assign w_px_cells = PROD_W'(i_cell.data.cell_col) * PROD_W'(w_stride);
    assign w_py_cells = PROD_W'(i_cell.data.cell_row) * PROD_W'(w_stride);
    assign w_px       = {w_px_cells, {FRAC_W{1'b0}}};
    assign w_py       = {w_py_cells, {FRAC_W{1'b0}}};
    assign w_keep     = w_lvl_ok && (i_cell.data.cell_logit >= i_cfg.logit_threshold);

    always_comb begin
        n_edges.valid = i_cell.valid && w_keep;
        n_edges.x1    = $signed({2'b00, w_px}) - EDGE_W'(i_cell.data.dist_left);
        n_edges.y1    = $signed({2'b00, w_py}) - EDGE_W'(i_cell.data.dist_top);
        n_edges.x2    = $signed({2'b00, w_px}) + EDGE_W'(i_cell.data.dist_right);
        n_edges.y2    = $signed({2'b00, w_py}) + EDGE_W'(i_cell.data.dist_bottom);
        n_edges.logit = i_cell.data.cell_logit;
    end

    assign w_ready      = !r_valid || i_next_ready;
    assign i_cell.ready = w_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_ready) begin
            r_valid <= n_edges.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready && n_edges.valid) begin
            r_edges <= n_edges;
        end
    end

    always_comb begin
        o_edges       = r_edges;
        o_edges.valid = r_valid;
    end

endmodule

`default_nettype wire

>>> rtl/afbd_clip.sv
// afbd_clip: clamps the raw edges to the model input, applies the minimum
// size test and holds the result register. Depends on afbd_pkg, afbd_box_if.
`timescale 1ns / 1ps
`default_nettype none

module afbd_clip
    import afbd_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  t_cfg        i_cfg,
    input  t_edges      i_edges,
    output logic        o_ready,
    afbd_box_if.source  o_box
);

    function automatic logic [COORD_W-1:0] clamp_edge(
        input logic signed [EDGE_W-1:0] v,
        input logic [COORD_W-1:0]       hi
    );
        logic [COORD_W-1:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v > $signed({{(EDGE_W-COORD_W){1'b0}}, hi})) begin
            res = hi;
        end else begin
            res = v[COORD_W-1:0];
        end
        return res;
    endfunction

    logic [COORD_W-1:0]        w_xmax;
    logic [COORD_W-1:0]        w_ymax;
    t_box                      n_box;
    logic signed [COORD_W:0]   w_w;
    logic signed [COORD_W:0]   w_h;
    logic signed [COORD_W:0]   w_min;
    logic                      w_keep;
    logic                      r_valid;
    t_box                      r_box;

    assign w_xmax = {i_cfg.model_width, {FRAC_W{1'b0}}};
    assign w_ymax = {i_cfg.model_height, {FRAC_W{1'b0}}};

    always_comb begin
        n_box.box_x1    = clamp_edge(i_edges.x1, w_xmax);
        n_box.box_y1    = clamp_edge(i_edges.y1, w_ymax);
        n_box.box_x2    = clamp_edge(i_edges.x2, w_xmax);
        n_box.box_y2    = clamp_edge(i_edges.y2, w_ymax);
        n_box.box_logit = i_edges.logit;
    end

    assign w_w    = $signed({1'b0, n_box.box_x2}) - $signed({1'b0, n_box.box_x1});
    assign w_h    = $signed({1'b0, n_box.box_y2}) - $signed({1'b0, n_box.box_y1});
    assign w_min  = $signed({1'b0, i_cfg.min_box_size});
    assign w_keep = i_edges.valid && (w_w > w_min) && (w_h > w_min);

    assign o_ready = !r_valid || o_box.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= w_keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && w_keep) begin
            r_box <= n_box;
        end
    end

    assign o_box.valid = r_valid;
    assign o_box.data  = r_box;

endmodule

`default_nettype wire

>>> rtl/afbd_checker.sv
// afbd_checker: port-level assertions for the box decode filter, bound to
// the top level. Depends on afbd_pkg and anchor_free_box_decode_filter.
`timescale 1ns / 1ps
`default_nettype none

module afbd_checker
    import afbd_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_out_valid,
    input wire logic i_out_ready,
    input t_box      i_out_data
);

    localparam logic [COORD_W-1:0] COORD_MAX = {{(COORD_W-FRAC_W){1'b1}}, {FRAC_W{1'b0}}};

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_box_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_data.box_x2 > i_out_data.box_x1)
                     && (i_out_data.box_y2 > i_out_data.box_y1))
        else $error("box edges not ordered");

    a_box_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_data.box_x2 <= COORD_MAX) && (i_out_data.box_y2 <= COORD_MAX))
        else $error("box edge beyond clamp range");

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_data))
        else $error("result changed while stalled");

endmodule

bind anchor_free_box_decode_filter afbd_checker u_afbd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_box.valid),
    .i_out_ready (o_box.ready),
    .i_out_data  (o_box.data)
);

`default_nettype wire
